// File: src/rgb_pixel_blend_unit_defines.svh
// Assertion macros for the RGB pixel blend unit.
// Included by the top level; it depends on nothing else.
`ifndef RGB_PIXEL_BLEND_UNIT_DEFINES_SVH
`define RGB_PIXEL_BLEND_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RPBU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rgb_pixel_blend_unit: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RPBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rgb_pixel_blend_unit: next-cycle check failed");

`endif

// File: src/rpbu_pkg.sv
// Package for the RGB pixel blend unit: command and register codes,
// channel constants and the per-channel arithmetic. No dependencies.
`default_nettype none

package rpbu_pkg;

    localparam logic [2:0] CMD_MULTIPLY = 3'd0;
    localparam logic [2:0] CMD_SUBTRACT = 3'd1;
    localparam logic [2:0] CMD_SCREEN   = 3'd2;
    localparam logic [2:0] CMD_OVERLAY  = 3'd3;
    localparam logic [2:0] CMD_ADD      = 3'd4;
    localparam logic [2:0] CMD_SCALE    = 3'd5;
    localparam logic [2:0] CMD_SPLIT    = 3'd6;

    localparam logic [1:0] CFG_OFFSET = 2'd0;
    localparam logic [1:0] CFG_GAIN   = 2'd1;
    localparam logic [1:0] CFG_TARGET = 2'd2;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam int unsigned NUM_CH     = 3;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [7:0]  CHAN_MAX          = 8'd255;
    localparam logic [7:0]  OVERLAY_THRESHOLD = 8'd127;
    localparam logic [16:0] ROUND_DIV255      = 17'd127;
    localparam logic [19:0] ROUND_Q8          = 20'd128;
    localparam logic [8:0]  OFFSET_RESET      = 9'd0;
    localparam logic [11:0] GAIN_RESET        = 12'd256;
    localparam logic [1:0]  TARGET_RESET      = CH_RED;

    // Floor of x/255 for x below 130560 (255*512). The estimate x*257/65536 is never
    // high and at most one low, so a single remainder check corrects it.
    function automatic logic [8:0] div255(input logic [16:0] x);
        logic [16:0] t;
        logic [8:0]  q;
        logic [16:0] qx;
        logic [16:0] r;
        t  = x + {8'd0, x[16:8]};
        q  = t[16:8];
        qx = {q, 8'd0} - {8'd0, q};
        r  = x - qx;
        if (r >= 17'd255) begin
            q = q + 9'd1;
        end
        return q;
    endfunction

    // Multiply, subtract, screen and overlay for one channel, sharing one
    // 8x8 product between the direct and the inverted forms.
    function automatic logic [7:0] blend_chan(input logic [2:0] cmd,
                                              input logic [7:0] a,
                                              input logic [7:0] b);
        logic        direct;
        logic        ovl_hi;
        logic [7:0]  ma;
        logic [7:0]  mb;
        logic [15:0] prod;
        logic [16:0] num;
        logic [8:0]  q;
        logic [8:0]  dbl;
        logic [7:0]  res;
        direct = (cmd == CMD_MULTIPLY) || ((cmd == CMD_OVERLAY) && (a < OVERLAY_THRESHOLD));
        ovl_hi = (cmd == CMD_OVERLAY) && !(a < OVERLAY_THRESHOLD);
        ma     = direct ? a : ~a;
        mb     = direct ? b : ~b;
        prod   = 16'(ma) * 16'(mb);
        num    = ovl_hi ? ({prod, 1'b0} + ROUND_DIV255) : ({1'b0, prod} + ROUND_DIV255);
        q      = div255(num);
        dbl    = {q[7:0], 1'b0};
        case (cmd)
            CMD_MULTIPLY: begin
                res = q[7:0];
            end
            CMD_SUBTRACT: begin
                res = (a > b) ? (a - b) : 8'd0;
            end
            CMD_SCREEN: begin
                res = CHAN_MAX - q[7:0];
            end
            CMD_OVERLAY: begin
                if (direct) begin
                    res = (dbl > {1'b0, CHAN_MAX}) ? CHAN_MAX : dbl[7:0];
                end else begin
                    res = (q >= {1'b0, CHAN_MAX}) ? 8'd0 : (CHAN_MAX - q[7:0]);
                end
            end
            default: begin
                res = a;
            end
        endcase
        return res;
    endfunction

    // Signed offset added to a channel, clamped to the channel range.
    function automatic logic [7:0] add_chan(input logic [7:0] a, input logic [8:0] off);
        logic signed [9:0] s;
        logic [7:0]        res;
        s = $signed({2'b00, a}) + $signed({off[8], off});
        if (s < 10'sd0) begin
            res = 8'd0;
        end else if (s > $signed({2'b00, CHAN_MAX})) begin
            res = CHAN_MAX;
        end else begin
            res = s[7:0];
        end
        return res;
    endfunction

    // Q4.8 gain, rounded half up and clamped at the channel maximum.
    function automatic logic [7:0] scale_chan(input logic [7:0] a, input logic [11:0] gain);
        logic [19:0] p;
        logic [11:0] v;
        p = 20'(a) * 20'(gain) + ROUND_Q8;
        v = p[19:8];
        return (v > {4'd0, CHAN_MAX}) ? CHAN_MAX : v[7:0];
    endfunction

endpackage

`default_nettype wire

// File: src/rgb_pixel_blend_unit.sv
// An accepted item is registered in the input register, and its result then in the output
// register once that register is empty or being read; the result is taken from there.
// Throughput: one item per clock while the output is not stalled; the input register and the
// result register each advance whenever the stage after them is empty or being emptied.
// Reset (synchronous, active low) empties both stages and sets the offset to 0,
// the gain to 1.0 and the target channel to red. Configuration is always ready.
// Depends on rpbu_pkg and rgb_pixel_blend_unit_defines.svh.
`default_nettype none
`include "rgb_pixel_blend_unit_defines.svh"

module rgb_pixel_blend_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_top_red,
    input  wire logic [7:0]  i_top_green,
    input  wire logic [7:0]  i_top_blue,
    input  wire logic [7:0]  i_bottom_red,
    input  wire logic [7:0]  i_bottom_green,
    input  wire logic [7:0]  i_bottom_blue,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [rpbu_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [8:0]  r_offset;
    logic [11:0] r_gain;
    logic [1:0]  r_target;

    logic        r_s1_valid;
    logic [2:0]  r_cmd;
    logic [7:0]  r_top [rpbu_pkg::NUM_CH];
    logic [7:0]  r_bot [rpbu_pkg::NUM_CH];

    logic        r_out_valid;
    logic [7:0]  r_out [rpbu_pkg::NUM_CH];

    logic        w_s2_load;
    logic        w_s1_load;
    logic [7:0]  w_sel_top;
    logic        w_sel_ok;
    logic [7:0]  w_add_res;
    logic [7:0]  w_scale_res;
    logic [7:0]  n_out [rpbu_pkg::NUM_CH];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= rpbu_pkg::OFFSET_RESET;
            r_gain   <= rpbu_pkg::GAIN_RESET;
            r_target <= rpbu_pkg::TARGET_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rpbu_pkg::CFG_OFFSET: r_offset <= i_cfg_data[8:0];
                rpbu_pkg::CFG_GAIN:   r_gain   <= i_cfg_data[11:0];
                rpbu_pkg::CFG_TARGET: r_target <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // The result register takes a new item when it is empty or being read;
    // the input register follows when it is empty or passing its item on.
    assign w_s2_load = !r_out_valid || !i_stall;
    assign w_s1_load = !r_s1_valid || w_s2_load;
    assign o_stall   = !w_s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load && i_valid) begin
            r_cmd    <= i_command;
            r_top[0] <= i_top_red;
            r_top[1] <= i_top_green;
            r_top[2] <= i_top_blue;
            r_bot[0] <= i_bottom_red;
            r_bot[1] <= i_bottom_green;
            r_bot[2] <= i_bottom_blue;
        end
    end

    always_comb begin
        w_sel_ok = 1'b1;
        case (r_target)
            rpbu_pkg::CH_RED:   w_sel_top = r_top[0];
            rpbu_pkg::CH_GREEN: w_sel_top = r_top[1];
            rpbu_pkg::CH_BLUE:  w_sel_top = r_top[2];
            default: begin
                w_sel_top = 8'd0;
                w_sel_ok  = 1'b0;
            end
        endcase
    end

    assign w_add_res   = rpbu_pkg::add_chan(w_sel_top, r_offset);
    assign w_scale_res = rpbu_pkg::scale_chan(w_sel_top, r_gain);

    always_comb begin
        for (int i = 0; i < rpbu_pkg::NUM_CH; i++) begin
            case (r_cmd)
                rpbu_pkg::CMD_MULTIPLY, rpbu_pkg::CMD_SUBTRACT,
                rpbu_pkg::CMD_SCREEN, rpbu_pkg::CMD_OVERLAY: begin
                    n_out[i] = rpbu_pkg::blend_chan(r_cmd, r_top[i], r_bot[i]);
                end
                rpbu_pkg::CMD_ADD: begin
                    n_out[i] = (w_sel_ok && (r_target == 2'(i))) ? w_add_res : r_top[i];
                end
                rpbu_pkg::CMD_SCALE: begin
                    n_out[i] = (w_sel_ok && (r_target == 2'(i))) ? w_scale_res : r_top[i];
                end
                rpbu_pkg::CMD_SPLIT: begin
                    n_out[i] = w_sel_top;
                end
                default: begin
                    n_out[i] = r_top[i];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load && r_s1_valid) begin
            r_out[0] <= n_out[0];
            r_out[1] <= n_out[1];
            r_out[2] <= n_out[2];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];

    `RPBU_ASSERT_NEXT(a_in_to_s1, i_clk, i_rst_n, i_valid && !o_stall, r_s1_valid)
    `RPBU_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_stall,
                      r_s1_valid && r_out_valid && i_stall)
    `RPBU_ASSERT_NEXT(a_s1_to_out, i_clk, i_rst_n, r_s1_valid && w_s2_load, o_valid)
    `RPBU_ASSERT_NEXT(a_held_result, i_clk, i_rst_n, o_valid && i_stall,
                      o_valid && $stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue))

endmodule

`default_nettype wire

// File: tb/tb_rgb_pixel_blend_unit.sv
// Self-checking testbench for the RGB pixel blend unit: a directed table, then random pixels
// under three idling patterns and several register settings, checked against a local predictor.
// Depends on rpbu_pkg and the rgb_pixel_blend_unit top level.

module tb_rgb_pixel_blend_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_PASS       = 3'd7;  // not a command: top pixel passes through
    localparam logic [1:0] CFG_UNUSED     = 2'd3;  // index with no register behind it
    localparam logic [1:0] CH_NONE        = 2'd3;  // target with no channel behind it
    localparam int         DRAIN_CYCLES   = 4;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         SETTINGS_PER_PHASE = 4;
    localparam int         PIXELS_PER_SETTING = 71;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [8:0]  offset;
        logic [11:0] gain;
        logic [1:0]  target;
        logic [2:0]  cmd;
        t_pixel      top;
        t_pixel      bottom;
        logic        known;
        t_pixel      result;
    } t_directed_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [2:0]            i_command;
    logic [7:0]            i_top_red;
    logic [7:0]            i_top_green;
    logic [7:0]            i_top_blue;
    logic [7:0]            i_bottom_red;
    logic [7:0]            i_bottom_green;
    logic [7:0]            i_bottom_blue;
    logic                  o_valid;
    logic                  i_stall;
    logic [7:0]            o_out_red;
    logic [7:0]            o_out_green;
    logic [7:0]            o_out_blue;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index;
    logic [rpbu_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Register copies held by the predictor.
    logic [8:0]  cur_offset = rpbu_pkg::OFFSET_RESET;
    logic [11:0] cur_gain   = rpbu_pkg::GAIN_RESET;
    logic [1:0]  cur_target = rpbu_pkg::TARGET_RESET;

    t_pixel        expected_pixels[$];
    t_directed_row directed_rows[$];
    int            fail_count     = 0;
    int            pixels_sent    = 0;
    int            results_seen   = 0;
    int            writes_done    = 0;
    int            send_idle_pct  = 38;
    int            stall_pct      = 77;

    rgb_pixel_blend_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_top_red      (i_top_red),
        .i_top_green    (i_top_green),
        .i_top_blue     (i_top_blue),
        .i_bottom_red   (i_bottom_red),
        .i_bottom_green (i_bottom_green),
        .i_bottom_blue  (i_bottom_blue),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int blend_channel(input logic [2:0] cmd, input int a, input int b);
        int v;
        case (cmd)
            rpbu_pkg::CMD_MULTIPLY: begin
                v = (a * b + 127) / 255;
            end
            rpbu_pkg::CMD_SUBTRACT: begin
                v = (a > b) ? a - b : 0;
            end
            rpbu_pkg::CMD_SCREEN: begin
                v = 255 - ((255 - a) * (255 - b) + 127) / 255;
            end
            rpbu_pkg::CMD_OVERLAY: begin
                if (a < rpbu_pkg::OVERLAY_THRESHOLD) begin
                    v = 2 * ((a * b + 127) / 255);
                    if (v > 255) v = 255;
                end else begin
                    v = (2 * (255 - a) * (255 - b) + 127) / 255;
                    v = (v >= 255) ? 0 : 255 - v;
                end
            end
            default: begin
                v = a;
            end
        endcase
        return v;
    endfunction

    // Expected output pixel for one input item under the current register values.
    function automatic t_pixel blend_pixel(input logic [2:0] cmd, input t_pixel top,
                                           input t_pixel bottom);
        int     a[3];
        int     b[3];
        int     r[3];
        int     off;
        int     v;
        t_pixel p;
        a = '{int'(top.red), int'(top.green), int'(top.blue)};
        b = '{int'(bottom.red), int'(bottom.green), int'(bottom.blue)};
        r = a;
        off = int'($signed(cur_offset));
        if (cmd <= rpbu_pkg::CMD_OVERLAY) begin
            for (int k = 0; k < 3; k++) r[k] = blend_channel(cmd, a[k], b[k]);
        end else if (cmd == rpbu_pkg::CMD_ADD && cur_target != CH_NONE) begin
            v = a[cur_target] + off;
            r[cur_target] = (v < 0) ? 0 : (v > 255) ? 255 : v;
        end else if (cmd == rpbu_pkg::CMD_SCALE && cur_target != CH_NONE) begin
            v = (a[cur_target] * int'(cur_gain) + 128) >> 8;
            r[cur_target] = (v > 255) ? 255 : v;
        end else if (cmd == rpbu_pkg::CMD_SPLIT) begin
            v = (cur_target != CH_NONE) ? a[cur_target] : 0;
            r = '{v, v, v};
        end
        p.red   = 8'(r[0]);
        p.green = 8'(r[1]);
        p.blue  = 8'(r[2]);
        return p;
    endfunction

    // Mostly uniform, with the extremes and the overlay threshold now and then.
    function automatic logic [7:0] pick_level();
        logic [7:0] v;
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(4))
                0: v = 8'd0;
                1: v = 8'd255;
                2: v = 8'd126;
                3: v = 8'd127;
                default: v = 8'd128;
            endcase
        end else begin
            v = 8'($urandom_range(255));
        end
        return v;
    endfunction

    task automatic add_row(input logic [8:0] offset, input logic [11:0] gain,
                           input logic [1:0] target, input logic [2:0] cmd,
                           input t_pixel top, input t_pixel bottom,
                           input logic known, input t_pixel result);
        t_directed_row row;
        row = {offset, gain, target, cmd, top, bottom, known, result};
        directed_rows = {directed_rows, row};
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic push_pixel(input logic [2:0] cmd, input t_pixel top, input t_pixel bottom,
                              input logic known, input t_pixel result);
        t_pixel want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_top_red      <= top.red;
        i_top_green    <= top.green;
        i_top_blue     <= top.blue;
        i_bottom_red   <= bottom.red;
        i_bottom_green <= bottom.green;
        i_bottom_blue  <= bottom.blue;
        do @(posedge i_clk); while (o_stall);
        want = known ? result : blend_pixel(cmd, top, bottom);
        expected_pixels = {expected_pixels, want};
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx,
                                  input logic [rpbu_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rpbu_pkg::CFG_OFFSET: cur_offset = data[8:0];
            rpbu_pkg::CFG_GAIN:   cur_gain   = data[11:0];
            rpbu_pkg::CFG_TARGET: cur_target = data[1:0];
            default: ;
        endcase
        writes_done++;
        @(negedge i_clk);
    endtask

    // Lets the block empty, then writes every register, unused upper data bits at random.
    task automatic apply_setting(input logic [8:0] offset, input logic [11:0] gain,
                                 input logic [1:0] target);
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        write_register(rpbu_pkg::CFG_OFFSET, {3'($urandom), offset});
        write_register(rpbu_pkg::CFG_GAIN, gain);
        write_register(rpbu_pkg::CFG_TARGET, {10'($urandom), target});
        write_register(CFG_UNUSED, 12'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
                $display("%0t ns: result with none expected, got %0d %0d %0d",
                         $time, o_out_red, o_out_green, o_out_blue);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("out_red", want.red, o_out_red);
                check_field("out_green", want.green, o_out_green);
                check_field("out_blue", want.blue, o_out_blue);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_rgb_pixel_blend_unit: errors");
        $finish;
    end

    initial begin : stimulus
        t_directed_row row;
        logic [8:0]    offset;
        logic [11:0]   gain;
        t_pixel        top;
        t_pixel        bottom;
        logic [2:0]    cmd;

        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_command      = rpbu_pkg::CMD_MULTIPLY;
        i_top_red      = 8'd0;
        i_top_green    = 8'd0;
        i_top_blue     = 8'd0;
        i_bottom_red   = 8'd0;
        i_bottom_green = 8'd0;
        i_bottom_blue  = 8'd0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = rpbu_pkg::CFG_OFFSET;
        i_cfg_data     = '0;

        // Reset register values first, then the signed and gain extremes, then no target.
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, rpbu_pkg::CMD_MULTIPLY,
                24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF);
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, rpbu_pkg::CMD_MULTIPLY,
                24'h000000, 24'hFFFFFF, 1'b1, 24'h000000);
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, rpbu_pkg::CMD_MULTIPLY,
                24'h80407F, 24'h7F80C0, 1'b0, 24'h0);
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, rpbu_pkg::CMD_SUBTRACT,
                24'h000000, 24'hFFFFFF, 1'b1, 24'h000000);
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, rpbu_pkg::CMD_SUBTRACT,
                24'hFFFFFF, 24'h000000, 1'b1, 24'hFFFFFF);
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, rpbu_pkg::CMD_SUBTRACT,
                24'h64C810, 24'h32C820, 1'b0, 24'h0);
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, rpbu_pkg::CMD_SCREEN,
                24'h000000, 24'h000000, 1'b1, 24'h000000);
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, rpbu_pkg::CMD_SCREEN,
                24'hFFFFFF, 24'h123456, 1'b1, 24'hFFFFFF);
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, rpbu_pkg::CMD_OVERLAY,
                24'h7E7F80, 24'hFFFFFF, 1'b0, 24'h0);
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, rpbu_pkg::CMD_OVERLAY,
                24'hFF7F00, 24'h000000, 1'b1, 24'hFF0000);
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, rpbu_pkg::CMD_ADD,
                24'h0A141E, 24'hFFFFFF, 1'b1, 24'h0A141E);
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, rpbu_pkg::CMD_SCALE,
                24'h0A141E, 24'hFFFFFF, 1'b1, 24'h0A141E);
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, rpbu_pkg::CMD_SPLIT,
                24'h0A141E, 24'hFFFFFF, 1'b1, 24'h0A0A0A);
        add_row(9'h000, 12'd256, rpbu_pkg::CH_RED, CMD_PASS,
                24'h5AA5C3, 24'hFFFFFF, 1'b1, 24'h5AA5C3);
        add_row(9'h101, 12'hFFF, rpbu_pkg::CH_GREEN, rpbu_pkg::CMD_ADD,
                24'hFFC8FF, 24'h000000, 1'b1, 24'hFF00FF);
        add_row(9'h101, 12'hFFF, rpbu_pkg::CH_GREEN, rpbu_pkg::CMD_SCALE,
                24'h010101, 24'h000000, 1'b1, 24'h011001);
        add_row(9'h101, 12'hFFF, rpbu_pkg::CH_GREEN, rpbu_pkg::CMD_SCALE,
                24'h7FFF7F, 24'h000000, 1'b1, 24'h7FFF7F);
        add_row(9'h101, 12'hFFF, rpbu_pkg::CH_GREEN, rpbu_pkg::CMD_SPLIT,
                24'h112233, 24'h000000, 1'b1, 24'h222222);
        add_row(9'h0FF, 12'd0, rpbu_pkg::CH_BLUE, rpbu_pkg::CMD_ADD,
                24'h000001, 24'h000000, 1'b1, 24'h0000FF);
        add_row(9'h0FF, 12'd0, rpbu_pkg::CH_BLUE, rpbu_pkg::CMD_SCALE,
                24'hFFFFFF, 24'h000000, 1'b1, 24'hFFFF00);
        add_row(9'h100, 12'h080, rpbu_pkg::CH_BLUE, rpbu_pkg::CMD_ADD,
                24'h0000FF, 24'h000000, 1'b1, 24'h000000);
        add_row(9'h100, 12'h080, rpbu_pkg::CH_BLUE, rpbu_pkg::CMD_SCALE,
                24'h000003, 24'h000000, 1'b1, 24'h000002);
        add_row(9'h0FF, 12'd256, CH_NONE, rpbu_pkg::CMD_ADD,
                24'h123456, 24'h000000, 1'b1, 24'h123456);
        add_row(9'h0FF, 12'd256, CH_NONE, rpbu_pkg::CMD_SCALE,
                24'h123456, 24'h000000, 1'b1, 24'h123456);
        add_row(9'h0FF, 12'd256, CH_NONE, rpbu_pkg::CMD_SPLIT,
                24'h123456, 24'h000000, 1'b1, 24'h000000);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.offset != cur_offset || row.gain != cur_gain || row.target != cur_target) begin
                apply_setting(row.offset, row.gain, row.target);
            end
            push_pixel(row.cmd, row.top, row.bottom, row.known, row.result);
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 77 : 0;
            stall_pct     = (phase == 0) ? 77 : (phase == 1) ? 38 : 0;
            for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
                case ($urandom_range(3))
                    0: offset = 9'h101;
                    1: offset = 9'h0FF;
                    default: offset = 9'($urandom);
                endcase
                case ($urandom_range(3))
                    0: gain = 12'd0;
                    1: gain = 12'hFFF;
                    2: gain = rpbu_pkg::GAIN_RESET;
                    default: gain = 12'($urandom);
                endcase
                apply_setting(offset, gain, 2'($urandom_range(3)));
                for (int n = 0; n < PIXELS_PER_SETTING; n++) begin
                    cmd    = ($urandom_range(19) == 0) ? CMD_PASS : 3'($urandom_range(6));
                    top    = {pick_level(), pick_level(), pick_level()};
                    bottom = {pick_level(), pick_level(), pick_level()};
                    push_pixel(cmd, top, bottom, 1'b0, 24'h0);
                end
            end
        end

        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge i_clk);
        repeat (2 * DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d pixels over every command and the undefined code; %0d results checked.",
                 pixels_sent, results_seen);
        $display("%0d register writes, the unused index among them, under three idling patterns.",
                 writes_done);
        if (fail_count == 0 && expected_pixels.size() == 0) begin
            $display("tb_rgb_pixel_blend_unit: clean");
        end else begin
            $display("tb_rgb_pixel_blend_unit: errors");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/rpbu_pkg.sv
src/rgb_pixel_blend_unit.sv
tb/tb_rgb_pixel_blend_unit.sv
